FILE: design/button_debounce_gesture_events_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the button debounce gesture event block
// Shared concurrent assertion wrappers for the checker.
// ---------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_GESTURE_EVENTS_DEFINES_SVH
`define BUTTON_DEBOUNCE_GESTURE_EVENTS_DEFINES_SVH

// Assertion on an explicit clock and active-low reset
`define BDGE_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the block's own clock and reset
`define BDGE_ASSERT(lbl, prop, msg) \
  `BDGE_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: design/bdge_pkg.sv
// ---------------------------------------------------------------------------
// Button debounce gesture events package
// Event codes, register map, reset values and the event item type.
// ---------------------------------------------------------------------------
`default_nettype none

package bdge_pkg;

  localparam int unsigned TIME_BITS_DEF = 32;
  localparam int unsigned CFG_ADDR_W    = 3;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned STAMP_W       = 32;
  localparam int unsigned EVT_DEPTH     = 4;

  typedef enum logic [2:0] {
    EV_PRESSED   = 3'd0,
    EV_RELEASED  = 3'd1,
    EV_CLICKED   = 3'd2,
    EV_DOUBLE    = 3'd3,
    EV_LONGSTART = 3'd4,
    EV_REPEAT    = 3'd5,
    EV_LONGSTOP  = 3'd6
  } event_kind_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ACTIVE_LOW   = 3'd0,
    CFG_DEBOUNCE     = 3'd1,
    CFG_CLICK_WINDOW = 3'd2,
    CFG_LONG_PRESS   = 3'd3,
    CFG_REPEAT       = 3'd4
  } cfg_reg_e;

  localparam logic                  RST_ACTIVE_LOW   = 1'b1;
  localparam logic [CFG_DATA_W-1:0] RST_DEBOUNCE     = 16'd50;
  localparam logic [CFG_DATA_W-1:0] RST_CLICK_WINDOW = 16'd300;
  localparam logic [CFG_DATA_W-1:0] RST_LONG_PRESS   = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] RST_REPEAT       = 16'd200;

  typedef struct packed {
    event_kind_e          kind;
    logic [STAMP_W-1:0]   stamp;
    logic                 last;
  } evt_t;

endpackage

`default_nettype wire

FILE: design/bdge_evt_fifo.sv
// ---------------------------------------------------------------------------
// Event queue
// Small register queue: up to two in and one out per cycle, out only if ready.
// ---------------------------------------------------------------------------
`default_nettype none

module bdge_evt_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [1:0]     push_n_i,
  input  bdge_pkg::evt_t      push_evt_i [2],
  output logic                room_o,
  output logic                out_valid_o,
  output bdge_pkg::evt_t      out_evt_o,
  input  wire logic           out_ready_i
);
  import bdge_pkg::*;

  localparam int unsigned PTR_W = $clog2(EVT_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  evt_t             mem_q [EVT_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             pop;
  logic [PTR_W-1:0] wr_ptr_nxt;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_evt_o   = mem_q[rd_ptr_q];
  // two free slots needed, a poll may leave two events
  assign room_o      = (count_q <= CNT_W'(EVT_DEPTH - 2));
  assign wr_ptr_nxt  = wr_ptr_q + PTR_W'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_n_i);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop);
    count_d  = count_q + CNT_W'(push_n_i) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push_evt_i[0];
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push_evt_i[1];
    end
  end

endmodule

`default_nettype wire

FILE: design/button_debounce_gesture_events.sv
// ---------------------------------------------------------------------------
// Button debounce and gesture events
// Debounces a polled button and reports press, release, click, double-click
// and long-press events.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries polls: pin level and the current millisecond time. m_axis
//   carries events: kind in tuser, timestamp in tdata, tlast on the final
//   event of a poll. cfg_* writes the polarity and timing registers; write
//   them only while the block is idle, the block does not enforce this.
//   A poll is held in an input register, then evaluated combinationally and
//   its events (none, one or two) are pushed into a four-entry event queue.
//   Each poll passes the input register and then the event queue before its
//   first event reaches m_axis. One poll is taken per cycle while the queue
//   has room, and one event leaves per cycle while the receiver is ready.
//   A poll is evaluated only when the queue has two free entries; while the
//   receiver stalls the queue fills, then the input register holds and
//   s_axis_tready drops.
//   Reset clears all control state and loads the default register values; the
//   first poll after reset only records level and time and yields no event.
// ---------------------------------------------------------------------------
`default_nettype none

module button_debounce_gesture_events #(
  parameter int unsigned TIME_BITS = bdge_pkg::TIME_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // config write port
  input  wire logic                            cfg_we_i,
  input  wire logic [bdge_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [bdge_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // polls
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [39:0]                     s_axis_tdata,  // pin_level, now_time[31:0]
  // events
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [31:0]                          m_axis_tdata,  // event_time[31:0]
  output logic [2:0]                           m_axis_tuser,  // event_kind[2:0]
  output logic                                 m_axis_tlast   // last_of_poll
);
  import bdge_pkg::*;

  typedef logic [TIME_BITS-1:0] tm_t;

  // config
  logic                  active_low_q;
  logic [CFG_DATA_W-1:0] debounce_q, click_win_q, long_press_q, repeat_q;

  // input register
  logic                  in_vld_q, in_vld_d;
  logic                  in_pin_q;
  logic [STAMP_W-1:0]    in_now_q;
  logic                  s_take;
  logic                  process;
  logic                  room;

  // debouncer / gesture state
  logic started_q, started_d;
  logic last_raw_q, last_raw_d;
  logic stable_q, stable_d;
  logic long_q, long_d;
  logic click_q, click_d;
  tm_t  rct_q, rct_d;
  tm_t  press_q, press_d;
  tm_t  rep_q, rep_d;
  tm_t  rel_q, rel_d;

  tm_t  now;
  tm_t  deb_t, win_t, lpt_t, rpt_t;
  logic raw;
  logic [1:0] n_ev;
  evt_t evs [2];
  evt_t out_evt;

  function automatic evt_t mk_evt(event_kind_e k, tm_t t);
    evt_t e;
    e.kind  = k;
    e.stamp = STAMP_W'(t);
    e.last  = 1'b0;
    return e;
  endfunction

  // ---------------- config port ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_low_q <= RST_ACTIVE_LOW;
      debounce_q   <= RST_DEBOUNCE;
      click_win_q  <= RST_CLICK_WINDOW;
      long_press_q <= RST_LONG_PRESS;
      repeat_q     <= RST_REPEAT;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_ACTIVE_LOW:   active_low_q <= cfg_wdata_i[0];
        CFG_DEBOUNCE:     debounce_q   <= cfg_wdata_i;
        CFG_CLICK_WINDOW: click_win_q  <= cfg_wdata_i;
        CFG_LONG_PRESS:   long_press_q <= cfg_wdata_i;
        CFG_REPEAT:       repeat_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------- input register ----------------
  assign process       = in_vld_q && room;
  assign s_axis_tready = !in_vld_q || process;
  assign s_take        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_take) begin
      in_vld_d = 1'b1;
    end else if (process) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_pin_q <= s_axis_tdata[0];
      in_now_q <= s_axis_tdata[32:1];
    end
  end

  // ---------------- poll evaluation ----------------
  assign now   = TIME_BITS'(in_now_q);
  assign deb_t = TIME_BITS'(debounce_q);
  assign win_t = TIME_BITS'(click_win_q);
  assign lpt_t = TIME_BITS'(long_press_q);
  assign rpt_t = TIME_BITS'(repeat_q);
  assign raw   = active_low_q ? !in_pin_q : in_pin_q;

  always_comb begin
    started_d  = started_q;
    last_raw_d = last_raw_q;
    stable_d   = stable_q;
    long_d     = long_q;
    click_d    = click_q;
    rct_d      = rct_q;
    press_d    = press_q;
    rep_d      = rep_q;
    rel_d      = rel_q;
    n_ev       = 2'd0;
    evs[0]     = mk_evt(EV_PRESSED, now);
    evs[1]     = mk_evt(EV_PRESSED, now);

    if (process) begin
      if (!started_q) begin
        // first poll only records level and time
        started_d  = 1'b1;
        last_raw_d = raw;
        stable_d   = raw;
        rct_d      = now;
      end else begin
        if (raw != last_raw_q) begin
          last_raw_d = raw;
          rct_d      = now;
        end

        if ((raw != stable_q) && ((now - rct_d) >= deb_t)) begin
          stable_d = raw;
          if (raw) begin
            press_d         = now;
            long_d          = 1'b0;
            rep_d           = now;
            evs[n_ev[0]]    = mk_evt(EV_PRESSED, now);
            n_ev            = n_ev + 2'd1;
          end else begin
            evs[n_ev[0]]    = mk_evt(EV_RELEASED, now);
            n_ev            = n_ev + 2'd1;
            if (long_q) begin
              evs[n_ev[0]]  = mk_evt(EV_LONGSTOP, now);
              n_ev          = n_ev + 2'd1;
              long_d        = 1'b0;
              click_d       = 1'b0;
            end else if (click_q && ((now - rel_q) <= win_t)) begin
              evs[n_ev[0]]  = mk_evt(EV_DOUBLE, now);
              n_ev          = n_ev + 2'd1;
              click_d       = 1'b0;
            end else begin
              click_d       = 1'b1;
              rel_d         = now;
            end
          end
        end

        if (stable_d) begin
          if (!long_d && ((now - press_d) >= lpt_t)) begin
            long_d        = 1'b1;
            click_d       = 1'b0;
            rep_d         = now;
            evs[n_ev[0]]  = mk_evt(EV_LONGSTART, now);
            n_ev          = n_ev + 2'd1;
          end else if (long_d && ((now - rep_d) >= rpt_t)) begin
            rep_d         = now;
            evs[n_ev[0]]  = mk_evt(EV_REPEAT, now);
            n_ev          = n_ev + 2'd1;
          end
        end else if (click_d && ((now - rel_d) > win_t)) begin
          // click is stamped with its release time
          evs[n_ev[0]]    = mk_evt(EV_CLICKED, rel_d);
          n_ev            = n_ev + 2'd1;
          click_d         = 1'b0;
        end

        if (n_ev == 2'd1) begin
          evs[0].last = 1'b1;
        end else if (n_ev == 2'd2) begin
          evs[1].last = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q  <= 1'b0;
      last_raw_q <= 1'b0;
      stable_q   <= 1'b0;
      long_q     <= 1'b0;
      click_q    <= 1'b0;
      rct_q      <= '0;
      press_q    <= '0;
      rep_q      <= '0;
      rel_q      <= '0;
    end else begin
      started_q  <= started_d;
      last_raw_q <= last_raw_d;
      stable_q   <= stable_d;
      long_q     <= long_d;
      click_q    <= click_d;
      rct_q      <= rct_d;
      press_q    <= press_d;
      rep_q      <= rep_d;
      rel_q      <= rel_d;
    end
  end

  // ---------------- event queue ----------------
  bdge_evt_fifo u_evt_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (n_ev),
    .push_evt_i  (evs),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_evt_o   (out_evt),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = out_evt.stamp;
  assign m_axis_tuser = out_evt.kind;
  assign m_axis_tlast = out_evt.last;

endmodule

`default_nettype wire

FILE: design/bdge_chk.sv
// ---------------------------------------------------------------------------
// Button debounce gesture events checker
// Port-level checks on the event stream, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "button_debounce_gesture_events_defines.svh"

module bdge_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);
  import bdge_pkg::*;

  logic ev_stop, ev_dbl, ev_clk, ev_rel;
  logic ev_pair;
  logic out_take;

  assign ev_stop  = (m_axis_tuser == EV_LONGSTOP);
  assign ev_dbl   = (m_axis_tuser == EV_DOUBLE);
  assign ev_clk   = (m_axis_tuser == EV_CLICKED);
  assign ev_rel   = (m_axis_tuser == EV_RELEASED);
  assign ev_pair  = ev_stop || ev_dbl;
  assign out_take = m_axis_tvalid && m_axis_tready;

  // stalled event stays offered
  `BDGE_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "event dropped")

  // long-press stop and double-click end their poll; they only ever follow a release in it
  `BDGE_ASSERT(a_tail_last, m_axis_tvalid && ev_pair |-> m_axis_tlast, "stop/double not last")

  // a click is always the only event of its poll
  `BDGE_ASSERT(a_click_alone, m_axis_tvalid && ev_clk |-> m_axis_tlast, "click shares a poll")

  // a release that is not last is followed at once by stop or double-click
  `BDGE_ASSERT(a_rel_pair, out_take && ev_rel && !m_axis_tlast |=> m_axis_tvalid && ev_pair, "release unpaired")

  // the timestamp is not checked here
  logic [31:0] unused_stamp;
  assign unused_stamp = m_axis_tdata;

endmodule

bind button_debounce_gesture_events bdge_chk u_bdge_chk (.*);

`default_nettype wire

FILE: tb/button_debounce_gesture_events_tb.sv
// ---------------------------------------------------------------------------
// Button debounce gesture events testbench
// Sends polls (pin level and millisecond time) with random gaps and checks
// every event against a cycle-free model of the debouncer: directed press,
// click, double-click and long-press cases, timing extremes with time wrap,
// then phases of random button activity under several register settings.
// ---------------------------------------------------------------------------
module button_debounce_gesture_events_tb;
  import bdge_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned POLLS_PER_PHASE = 250;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [39:0]           s_axis_tdata;   // pin_level, now_time[31:0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [31:0]           m_axis_tdata;   // event_time[31:0]
  logic [2:0]            m_axis_tuser;   // event_kind[2:0]
  logic                  m_axis_tlast;

  button_debounce_gesture_events DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // model registers
  logic        cf_active_low;
  logic [15:0] cf_debounce;
  logic [15:0] cf_window;
  logic [15:0] cf_long;
  logic [15:0] cf_repeat;

  // model state
  logic        st_started;
  logic        st_last_raw;
  logic        st_pressed;
  logic        st_long;
  logic        st_click;
  logic [31:0] st_raw_t;
  logic [31:0] st_press_t;
  logic [31:0] st_rep_t;
  logic [31:0] st_rel_t;

  evt_t        pending_events[$];
  int unsigned mismatches;
  int unsigned poll_count;
  int unsigned event_count;
  int unsigned kind_seen[7];
  bit          tx_idle;
  bit          rx_idle;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] since(input logic [31:0] now, input logic [31:0] then);
    return now - then;
  endfunction

  function automatic evt_t make_evt(input event_kind_e kind, input logic [31:0] stamp);
    evt_t ev;
    ev.kind  = kind;
    ev.stamp = stamp;
    ev.last  = 1'b0;
    return ev;
  endfunction

  // Works out the events of one poll and queues them.
  function automatic void predict_gestures(input logic lvl, input logic [31:0] now);
    evt_t fresh[$];
    logic raw;
    raw = cf_active_low ? !lvl : lvl;
    if (!st_started) begin
      st_started  = 1'b1;
      st_last_raw = raw;
      st_pressed  = raw;
      st_raw_t    = now;
      return;
    end
    if (raw != st_last_raw) begin
      st_last_raw = raw;
      st_raw_t    = now;
    end
    if (raw != st_pressed && since(now, st_raw_t) >= 32'(cf_debounce)) begin
      st_pressed = raw;
      if (st_pressed) begin
        st_press_t = now;
        st_long    = 1'b0;
        st_rep_t   = now;
        fresh.push_back(make_evt(EV_PRESSED, now));
      end else begin
        fresh.push_back(make_evt(EV_RELEASED, now));
        if (st_long) begin
          fresh.push_back(make_evt(EV_LONGSTOP, now));
          st_long  = 1'b0;
          st_click = 1'b0;
        end else if (st_click && since(now, st_rel_t) <= 32'(cf_window)) begin
          fresh.push_back(make_evt(EV_DOUBLE, now));
          st_click = 1'b0;
        end else begin
          st_click = 1'b1;
          st_rel_t = now;
        end
      end
    end
    if (st_pressed) begin
      if (!st_long && since(now, st_press_t) >= 32'(cf_long)) begin
        st_long  = 1'b1;
        st_click = 1'b0;
        st_rep_t = now;
        fresh.push_back(make_evt(EV_LONGSTART, now));
      end else if (st_long && since(now, st_rep_t) >= 32'(cf_repeat)) begin
        st_rep_t = now;
        fresh.push_back(make_evt(EV_REPEAT, now));
      end
    end else if (st_click && since(now, st_rel_t) > 32'(cf_window)) begin
      // click is stamped with its release time
      fresh.push_back(make_evt(EV_CLICKED, st_rel_t));
      st_click = 1'b0;
    end
    if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
    foreach (fresh[i]) pending_events.push_back(fresh[i]);
  endfunction

  // Register write; only called while the block is idle.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= val;
    case (addr)
      CFG_ACTIVE_LOW:   cf_active_low = val[0];
      CFG_DEBOUNCE:     cf_debounce   = val;
      CFG_CLICK_WINDOW: cf_window     = val;
      CFG_LONG_PRESS:   cf_long       = val;
      CFG_REPEAT:       cf_repeat     = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(input logic al, input logic [15:0] deb, input logic [15:0] win,
                           input logic [15:0] lng, input logic [15:0] rep);
    write_reg(CFG_ACTIVE_LOW, {15'd0, al});
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_CLICK_WINDOW, win);
    write_reg(CFG_LONG_PRESS, lng);
    write_reg(CFG_REPEAT, rep);
  endtask

  // Sends one poll; returns at the edge that accepts it, tvalid still high.
  task automatic send_poll(input logic lvl, input logic [31:0] now);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, now, lvl};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_gestures(lvl, now);
    poll_count++;
  endtask

  // Stops polls and waits until every queued event has come out.
  task automatic settle_block();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Button held at the first poll: long press counts from time zero.
  task automatic test_first_poll_held();
    send_poll(1'b0, 32'd5);
    send_poll(1'b0, 32'd1000);
    send_poll(1'b0, 32'd1200);
    send_poll(1'b1, 32'd1250);
    send_poll(1'b1, 32'd1300);
  endtask

  task automatic test_click_and_double();
    // single click, reported once the window has passed
    send_poll(1'b0, 32'd1400);
    send_poll(1'b0, 32'd1450);
    send_poll(1'b1, 32'd1500);
    send_poll(1'b1, 32'd1550);
    send_poll(1'b1, 32'd1900);
    // double click inside the window, with a bounce on the first press
    send_poll(1'b0, 32'd2000);
    send_poll(1'b1, 32'd2010);
    send_poll(1'b0, 32'd2020);
    send_poll(1'b0, 32'd2070);
    send_poll(1'b1, 32'd2100);
    send_poll(1'b1, 32'd2150);
    send_poll(1'b0, 32'd2200);
    send_poll(1'b0, 32'd2250);
    send_poll(1'b1, 32'd2300);
    send_poll(1'b1, 32'd2350);
  endtask

  // High level is pressed, all timings zero: press brings long-press start
  // in the same poll; time wraps through zero while held.
  task automatic test_zero_timings();
    settle_block();
    write_all(1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_poll(1'b1, 32'hFFFF_FFFE);
    send_poll(1'b1, 32'hFFFF_FFFF);
    send_poll(1'b1, 32'h0000_0001);
    send_poll(1'b0, 32'h0000_0002);
  endtask

  task automatic test_wide_timings();
    int a;
    settle_block();
    write_all(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // unused register indexes must leave the settings alone
    for (a = int'(CFG_REPEAT) + 1; a < (1 << CFG_ADDR_W); a++)
      write_reg(CFG_ADDR_W'(a), 16'($urandom_range(0, 65535)));
    send_poll(1'b0, 32'h8000_0000);
    send_poll(1'b0, 32'h8000_FFFE);
    send_poll(1'b0, 32'h8000_FFFF);
    send_poll(1'b1, 32'h8001_0000);
    send_poll(1'b1, 32'h8002_0000);
  endtask

  // Random button activity: holds, bounces, glitches and time jumps.
  task automatic test_random_phases();
    int unsigned phase;
    int unsigned n;
    int unsigned hold;
    int unsigned bounce;
    int unsigned step_max;
    logic        intent;
    logic        pin;
    logic [31:0] clock_ms;
    intent = 1'b0;
    hold   = 0;
    bounce = 0;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle_block();
      tx_idle = (phase % 4) != 1;
      rx_idle = (phase % 4) != 2;
      case (phase)
        0: write_all(1'b1, 16'd0, 16'd0, 16'd0, 16'd0);
        1: write_all(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)));
        default: write_all(1'($urandom_range(0, 1)), 16'($urandom_range(0, 20)),
                           16'($urandom_range(0, 120)), 16'($urandom_range(0, 300)),
                           16'($urandom_range(0, 60)));
      endcase
      step_max = (phase == 1) ? 40000 : 32'(cf_debounce) + 8;
      clock_ms = (phase == 2) ? 32'hFFFF_FF00 : $urandom;
      for (n = 0; n < POLLS_PER_PHASE; n++) begin
        if (hold == 0) begin
          intent = !intent;
          hold   = $urandom_range(1, 60);
          bounce = $urandom_range(0, 3);
        end
        hold--;
        clock_ms += $urandom_range(0, step_max);
        pin = cf_active_low ? !intent : intent;
        if (bounce > 0) begin
          pin = 1'($urandom_range(0, 1));
          bounce--;
        end
        if ($urandom_range(0, 19) == 0) begin
          pin      = 1'($urandom_range(0, 1));
          clock_ms = $urandom;
        end
        send_poll(pin, clock_ms);
      end
    end
  endtask

  // event receiver with random stalls
  initial begin
    int unsigned gap;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      gap = rx_idle ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready && rst_ni));
    end
  end

  // event checker
  always @(posedge clk_i) begin
    evt_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event, got kind %0d time %0h last %0b",
                 $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        if (m_axis_tuser != want.kind || m_axis_tdata != want.stamp ||
            m_axis_tlast != want.last) begin
          $display("%0t: event mismatch, expected kind %0d time %0h last %0b, got kind %0d time %0h last %0b",
                   $time, want.kind, want.stamp, want.last,
                   m_axis_tuser, m_axis_tdata, m_axis_tlast);
          mismatches++;
        end
      end
      event_count++;
      if (m_axis_tuser < 3'd7) kind_seen[m_axis_tuser]++;
    end
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d events still expected", pending_events.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    tx_idle       = 1'b1;
    rx_idle       = 1'b1;
    mismatches    = 0;
    poll_count    = 0;
    event_count   = 0;
    cf_active_low = RST_ACTIVE_LOW;
    cf_debounce   = RST_DEBOUNCE;
    cf_window     = RST_CLICK_WINDOW;
    cf_long       = RST_LONG_PRESS;
    cf_repeat     = RST_REPEAT;
    st_started    = 1'b0;
    st_last_raw   = 1'b0;
    st_pressed    = 1'b0;
    st_long       = 1'b0;
    st_click      = 1'b0;
    st_raw_t      = '0;
    st_press_t    = '0;
    st_rep_t      = '0;
    st_rel_t      = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_first_poll_held();
    test_click_and_double();
    test_zero_timings();
    test_wide_timings();
    test_random_phases();
    settle_block();

    mismatches += pending_events.size();
    $display("%0d polls under default, zero, full-scale and random timings; %0d events checked",
             poll_count, event_count);
    $display("pressed %0d released %0d clicked %0d double %0d long %0d repeat %0d stop %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
             kind_seen[4], kind_seen[5], kind_seen[6]);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
